// File: hdl/rc_cc_pkg.sv
// rc_cc_pkg: shared types, constants and codes for the RC channel conditioner.
// No dependencies; the other files of the block, rc_cc_if apart, use it by scoped names.

package rc_cc_pkg;

   // Raw clamp range and pulse mapping
   localparam logic [10:0] RAW_MIN = 11'd172;
   localparam logic [10:0] RAW_MAX = 11'd1811;
   localparam logic [10:0] US_MIN  = 11'd1000;
   localparam logic [10:0] US_MID  = 11'd1500;
   localparam logic [11:0] INV_SUM = 12'd3000;

   // floor(d * 1000 / 1639) == (d * MAP_MULT) >> MAP_SHIFT for d in 0..1639
   localparam int          MAP_SHIFT  = 21;
   localparam int          MAP_PROD_W = 32;
   localparam logic [20:0] MAP_MULT   = 21'd1279532;

   // floor(a * 127 / 500) == (a * CMD_MULT) >> CMD_SHIFT for a in 0..500
   localparam int          CMD_SHIFT  = 20;
   localparam int          CMD_PROD_W = 28;
   localparam logic [18:0] CMD_MULT   = 19'd266339;

   // Operations
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_POLL   = 1'b1;

   // Channel codes
   localparam logic [2:0] CH_STEER    = 3'd0;
   localparam logic [2:0] CH_THROTTLE = 3'd1;
   localparam logic [2:0] CH_TOGGLE   = 3'd2;
   localparam logic [2:0] CH_OVERRIDE = 3'd3;
   localparam logic [2:0] CH_GEAR     = 3'd4;

   // Override modes
   localparam logic [1:0] MODE_HOST   = 2'd0;
   localparam logic [1:0] MODE_MUTED  = 2'd1;
   localparam logic [1:0] MODE_MANUAL = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_TOGGLE_HIGH = 3'd0;
   localparam logic [2:0] CSR_FS_LOW      = 3'd1;
   localparam logic [2:0] CSR_FS_HIGH     = 3'd2;
   localparam logic [2:0] CSR_MUTE_LOW    = 3'd3;
   localparam logic [2:0] CSR_MUTE_HIGH   = 3'd4;

   // Configuration reset values
   localparam logic [10:0] TOGGLE_HIGH_RESET = 11'd500;
   localparam logic [10:0] FS_LOW_RESET      = 11'd800;
   localparam logic [10:0] FS_HIGH_RESET     = 11'd1200;
   localparam logic [10:0] MUTE_LOW_RESET    = 11'd1400;
   localparam logic [10:0] MUTE_HIGH_RESET   = 11'd1600;

   // Channel state after reset: all raw values zero clamp to the low end
   localparam logic        [10:0] US_RESET        = 11'd1000;
   localparam logic        [10:0] THR_US_RESET    = 11'd2000;
   localparam logic signed [7:0]  STEER_CMD_RESET = -8'sd127;
   localparam logic signed [7:0]  THR_CMD_RESET   = 8'sd127;
   localparam logic        [10:0] TOG_RAW_RESET   = 11'd0;

   typedef struct packed {
      logic        op;
      logic [2:0]  channel;
      logic [10:0] raw_value;
   } req_item_type;

   typedef struct packed {
      logic               op;
      logic [2:0]         channel;
      logic [10:0]        raw_value;
      logic [10:0]        us;
      logic signed [7:0]  cmd;
   } map_item_type;

   typedef struct packed {
      logic [10:0] toggle_high_level;
      logic [10:0] failsafe_band_low;
      logic [10:0] failsafe_band_high;
      logic [10:0] mute_band_low_us;
      logic [10:0] mute_band_high_us;
   } cfg_type;

   typedef struct packed {
      logic [10:0]        steer_pulse;
      logic [10:0]        throttle_pulse;
      logic [10:0]        gear_us;
      logic [10:0]        override_us;
      logic [10:0]        toggle_us;
      logic signed [7:0]  steer_cmd;
      logic signed [7:0]  throttle_cmd;
      logic               high_gear;
      logic               override_on;
      logic [1:0]         override_mode;
      logic               link_up;
      logic               toggle_event;
   } rsp_item_type;

endpackage

// File: hdl/rc_cc_if.sv
// rc_cc_if: valid/ready channel interfaces for the request and result items.
// Depends on nothing; payload widths follow the block's field list.

interface rc_cc_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [2:0]  channel;
   logic [10:0] raw_value;

   modport source (output valid, output op, output channel, output raw_value, input ready);
   modport sink   (input valid, input op, input channel, input raw_value, output ready);
endinterface

interface rc_cc_rsp_if;
   logic               valid;
   logic               ready;
   logic [10:0]        steer_pulse;
   logic [10:0]        throttle_pulse;
   logic [10:0]        gear_us;
   logic [10:0]        override_us;
   logic [10:0]        toggle_us;
   logic signed [7:0]  steer_cmd;
   logic signed [7:0]  throttle_cmd;
   logic               high_gear;
   logic               override_on;
   logic [1:0]         override_mode;
   logic               link_up;
   logic               toggle_event;

   modport source (
      output valid, output steer_pulse, output throttle_pulse, output gear_us,
      output override_us, output toggle_us, output steer_cmd, output throttle_cmd,
      output high_gear, output override_on, output override_mode,
      output link_up, output toggle_event, input ready
   );
   modport sink (
      input valid, input steer_pulse, input throttle_pulse, input gear_us,
      input override_us, input toggle_us, input steer_cmd, input throttle_cmd,
      input high_gear, input override_on, input override_mode,
      input link_up, input toggle_event, output ready
   );
endinterface

// File: hdl/rc_cc_map.sv
// rc_cc_map: three-stage mapping pipeline, raw value to pulse width and command.
// Depends on rc_cc_pkg. Each stage holds at most one multiply.

module rc_cc_map (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  rc_cc_pkg::req_item_type in_item,
   output logic                    in_ready,
   output logic                    out_valid,
   output rc_cc_pkg::map_item_type out_item,
   input  logic                    out_ready
);

   logic                    s1_valid_ff, s1_valid_in;
   rc_cc_pkg::req_item_type s1_item_ff;
   logic                    s2_valid_ff, s2_valid_in;
   rc_cc_pkg::req_item_type s2_item_ff;
   logic [rc_cc_pkg::MAP_PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic                    s3_valid_ff, s3_valid_in;
   rc_cc_pkg::req_item_type s3_item_ff;
   logic [10:0]             s3_us_ff, s3_us_in;
   logic                    s3_neg_ff, s3_neg_in;
   logic [rc_cc_pkg::CMD_PROD_W-1:0] s3_prod_ff, s3_prod_in;

   logic        adv1, adv2, adv3;
   logic [10:0] clamped, offset;
   logic [10:0] us_map;
   logic [8:0]  mag;
   logic [7:0]  cmd_mag;

   assign adv3     = !s3_valid_ff || out_ready;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   // Stage 1: clamp and scale
   always_comb begin
      if (s1_item_ff.raw_value < rc_cc_pkg::RAW_MIN) begin
         clamped = rc_cc_pkg::RAW_MIN;
      end else if (s1_item_ff.raw_value > rc_cc_pkg::RAW_MAX) begin
         clamped = rc_cc_pkg::RAW_MAX;
      end else begin
         clamped = s1_item_ff.raw_value;
      end
      offset     = clamped - rc_cc_pkg::RAW_MIN;
      s2_prod_in = {21'd0, offset} * {11'd0, rc_cc_pkg::MAP_MULT};
   end

   // Stage 2: pulse width, throttle inversion, command magnitude
   always_comb begin
      us_map = rc_cc_pkg::US_MIN + s2_prod_ff[rc_cc_pkg::MAP_SHIFT +: 11];
      if (s2_item_ff.channel == rc_cc_pkg::CH_THROTTLE) begin
         s3_us_in = 11'(rc_cc_pkg::INV_SUM - {1'b0, us_map});
      end else begin
         s3_us_in = us_map;
      end
      s3_neg_in = s3_us_in < rc_cc_pkg::US_MID;
      if (s3_neg_in) begin
         mag = 9'(rc_cc_pkg::US_MID - s3_us_in);
      end else begin
         mag = 9'(s3_us_in - rc_cc_pkg::US_MID);
      end
      s3_prod_in = {19'd0, mag} * {9'd0, rc_cc_pkg::CMD_MULT};
   end

   // Stage 3: signed command, truncated toward zero
   always_comb begin
      cmd_mag = s3_prod_ff[rc_cc_pkg::CMD_SHIFT +: 8];
      out_item.op        = s3_item_ff.op;
      out_item.channel   = s3_item_ff.channel;
      out_item.raw_value = s3_item_ff.raw_value;
      out_item.us        = s3_us_ff;
      out_item.cmd       = s3_neg_ff ? -$signed(cmd_mag) : $signed(cmd_mag);
   end

   assign out_valid = s3_valid_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      s3_valid_in = s3_valid_ff;
      if (adv1) begin
         s1_valid_in = in_valid;
      end
      if (adv2) begin
         s2_valid_in = s1_valid_ff;
      end
      if (adv3) begin
         s3_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         s1_item_ff <= in_item;
      end
      if (adv2 && s1_valid_ff) begin
         s2_item_ff <= s1_item_ff;
         s2_prod_ff <= s2_prod_in;
      end
      if (adv3 && s2_valid_ff) begin
         s3_item_ff <= s2_item_ff;
         s3_us_ff   <= s3_us_in;
         s3_neg_ff  <= s3_neg_in;
         s3_prod_ff <= s3_prod_in;
      end
   end

endmodule

// File: hdl/rc_cc_state.sv
// rc_cc_state: channel state, toggle latch, link and mode decode, result register.
// Depends on rc_cc_pkg, rc_cc_if; fed in order by rc_cc_map.

module rc_cc_state (
   input  logic                    clock,
   input  logic                    reset,
   input  rc_cc_pkg::cfg_type      cfg,
   input  logic                    in_valid,
   input  rc_cc_pkg::map_item_type in_item,
   output logic                    in_ready,
   rc_cc_rsp_if.source             rsp_ch
);

   logic [10:0]       steer_pulse_ff, steer_pulse_in;
   logic [10:0]       thr_us_ff, thr_us_in;
   logic [10:0]       tog_us_ff, tog_us_in;
   logic [10:0]       ovr_us_ff, ovr_us_in;
   logic [10:0]       gear_us_ff, gear_us_in;
   logic signed [7:0] steer_cmd_ff, steer_cmd_in;
   logic signed [7:0] thr_cmd_ff, thr_cmd_in;
   logic [10:0]       tog_raw_ff, tog_raw_in;
   logic              was_high_ff, was_high_in;
   logic              latch_ff, latch_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rc_cc_pkg::rsp_item_type rsp_ff, rsp_in;

   logic       take;
   logic       high;
   logic       link;
   logic       event_bit;
   logic [1:0] mode;

   assign in_ready = !rsp_valid_ff || rsp_ch.ready;
   assign take     = in_valid && in_ready;
   assign high     = in_item.raw_value > cfg.toggle_high_level;

   // State after this item; the result shows it
   always_comb begin
      steer_pulse_in = steer_pulse_ff;
      thr_us_in      = thr_us_ff;
      tog_us_in      = tog_us_ff;
      ovr_us_in      = ovr_us_ff;
      gear_us_in     = gear_us_ff;
      steer_cmd_in   = steer_cmd_ff;
      thr_cmd_in     = thr_cmd_ff;
      tog_raw_in     = tog_raw_ff;
      was_high_in    = was_high_ff;
      latch_in       = latch_ff;
      event_bit      = 1'b0;
      if (take) begin
         if (in_item.op == rc_cc_pkg::OP_UPDATE) begin
            case (in_item.channel)
               rc_cc_pkg::CH_STEER: begin
                  steer_pulse_in = in_item.us;
                  steer_cmd_in   = in_item.cmd;
               end
               rc_cc_pkg::CH_THROTTLE: begin
                  thr_us_in  = in_item.us;
                  thr_cmd_in = in_item.cmd;
               end
               rc_cc_pkg::CH_TOGGLE: begin
                  tog_us_in   = in_item.us;
                  tog_raw_in  = in_item.raw_value;
                  was_high_in = high;
                  if (high && !was_high_ff) begin
                     latch_in = 1'b1;
                  end
               end
               rc_cc_pkg::CH_OVERRIDE: begin
                  ovr_us_in = in_item.us;
               end
               rc_cc_pkg::CH_GEAR: begin
                  gear_us_in = in_item.us;
               end
               default: begin
               end
            endcase
         end else begin
            event_bit = latch_ff;
            latch_in  = 1'b0;
         end
      end
   end

   always_comb begin
      link = (tog_raw_in < cfg.failsafe_band_low) || (tog_raw_in > cfg.failsafe_band_high);
      if (ovr_us_in < cfg.mute_band_low_us) begin
         mode = rc_cc_pkg::MODE_HOST;
      end else if (ovr_us_in <= cfg.mute_band_high_us) begin
         mode = rc_cc_pkg::MODE_MUTED;
      end else begin
         mode = rc_cc_pkg::MODE_MANUAL;
      end
      rsp_in.steer_pulse    = steer_pulse_in;
      rsp_in.throttle_pulse = thr_us_in;
      rsp_in.gear_us        = gear_us_in;
      rsp_in.override_us    = ovr_us_in;
      rsp_in.toggle_us      = tog_us_in;
      rsp_in.steer_cmd      = link ? steer_cmd_in : 8'sd0;
      rsp_in.throttle_cmd   = link ? thr_cmd_in : 8'sd0;
      rsp_in.high_gear      = link && (gear_us_in > rc_cc_pkg::US_MID);
      rsp_in.override_on    = (mode != rc_cc_pkg::MODE_HOST) || !link;
      rsp_in.override_mode  = mode;
      rsp_in.link_up        = link;
      rsp_in.toggle_event   = event_bit;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steer_pulse_ff <= rc_cc_pkg::US_RESET;
         thr_us_ff      <= rc_cc_pkg::THR_US_RESET;
         tog_us_ff      <= rc_cc_pkg::US_RESET;
         ovr_us_ff      <= rc_cc_pkg::US_RESET;
         gear_us_ff     <= rc_cc_pkg::US_RESET;
         steer_cmd_ff   <= rc_cc_pkg::STEER_CMD_RESET;
         thr_cmd_ff     <= rc_cc_pkg::THR_CMD_RESET;
         tog_raw_ff     <= rc_cc_pkg::TOG_RAW_RESET;
         was_high_ff    <= 1'b0;
         latch_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         steer_pulse_ff <= steer_pulse_in;
         thr_us_ff      <= thr_us_in;
         tog_us_ff      <= tog_us_in;
         ovr_us_ff      <= ovr_us_in;
         gear_us_ff     <= gear_us_in;
         steer_cmd_ff   <= steer_cmd_in;
         thr_cmd_ff     <= thr_cmd_in;
         tog_raw_ff     <= tog_raw_in;
         was_high_ff    <= was_high_in;
         latch_ff       <= latch_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.steer_pulse    = rsp_ff.steer_pulse;
   assign rsp_ch.throttle_pulse = rsp_ff.throttle_pulse;
   assign rsp_ch.gear_us        = rsp_ff.gear_us;
   assign rsp_ch.override_us    = rsp_ff.override_us;
   assign rsp_ch.toggle_us      = rsp_ff.toggle_us;
   assign rsp_ch.steer_cmd      = rsp_ff.steer_cmd;
   assign rsp_ch.throttle_cmd   = rsp_ff.throttle_cmd;
   assign rsp_ch.high_gear      = rsp_ff.high_gear;
   assign rsp_ch.override_on    = rsp_ff.override_on;
   assign rsp_ch.override_mode  = rsp_ff.override_mode;
   assign rsp_ch.link_up        = rsp_ff.link_up;
   assign rsp_ch.toggle_event   = rsp_ff.toggle_event;

   // A poll always leaves the latch clear
   a_poll_clears: assert property (@(posedge clock) disable iff (reset)
      take && (in_item.op == rc_cc_pkg::OP_POLL) |=> !latch_ff)
      else $error("toggle latch still set after poll");

   // Only a poll can report a toggle edge
   a_event_on_poll: assert property (@(posedge clock) disable iff (reset)
      take && (in_item.op == rc_cc_pkg::OP_UPDATE) |=> !rsp_ff.toggle_event)
      else $error("toggle event reported on an update item");

   // Link lost forces safe outputs
   a_link_lost_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.link_up |->
         (rsp_ff.steer_cmd == 8'sd0) && (rsp_ff.throttle_cmd == 8'sd0) &&
         !rsp_ff.high_gear && rsp_ff.override_on)
      else $error("commands not neutral with link lost");

   // A result appears only after an item was taken
   a_rsp_from_take: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(take))
      else $error("result valid without an accepted item");

endmodule

// File: hdl/rc_channel_conditioner.sv
// RC channel conditioner top level: config registers, mapping pipeline, state.
// Each item passes stage 1 (clamp and scale multiply), stage 2 (pulse and command
// multiply) and stage 3 (sign), then the result register.
// Throughput: one item per cycle while results are taken; each stage advances when the one after it is free.
// Reset (synchronous, active high): pipeline empty, channels read as raw zero,
// toggle latch clear, configuration at its default values.

module rc_channel_conditioner (
   input  logic        clock,
   input  logic        reset,
   rc_cc_req_if.sink   req_ch,
   rc_cc_rsp_if.source rsp_ch,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wr_data
);

   rc_cc_pkg::cfg_type      cfg_ff, cfg_in;
   rc_cc_pkg::req_item_type req_item;
   rc_cc_pkg::map_item_type map_item;
   logic                    map_valid;
   logic                    map_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rc_cc_pkg::CSR_TOGGLE_HIGH: cfg_in.toggle_high_level  = csr_wr_data;
            rc_cc_pkg::CSR_FS_LOW:      cfg_in.failsafe_band_low  = csr_wr_data;
            rc_cc_pkg::CSR_FS_HIGH:     cfg_in.failsafe_band_high = csr_wr_data;
            rc_cc_pkg::CSR_MUTE_LOW:    cfg_in.mute_band_low_us   = csr_wr_data;
            rc_cc_pkg::CSR_MUTE_HIGH:   cfg_in.mute_band_high_us  = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.toggle_high_level  <= rc_cc_pkg::TOGGLE_HIGH_RESET;
         cfg_ff.failsafe_band_low  <= rc_cc_pkg::FS_LOW_RESET;
         cfg_ff.failsafe_band_high <= rc_cc_pkg::FS_HIGH_RESET;
         cfg_ff.mute_band_low_us   <= rc_cc_pkg::MUTE_LOW_RESET;
         cfg_ff.mute_band_high_us  <= rc_cc_pkg::MUTE_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.op        = req_ch.op;
   assign req_item.channel   = req_ch.channel;
   assign req_item.raw_value = req_ch.raw_value;

   rc_cc_map u_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_item   (req_item),
      .in_ready  (req_ch.ready),
      .out_valid (map_valid),
      .out_item  (map_item),
      .out_ready (map_ready)
   );

   rc_cc_state u_state (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (map_valid),
      .in_item  (map_item),
      .in_ready (map_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule

// File: sim/rc_channel_conditioner_tb.sv
// Self-checking testbench for rc_channel_conditioner: directed and random channel items,
// register settings, random stalls on both channels. Depends on hdl/rc_cc_pkg.sv,
// hdl/rc_cc_if.sv and hdl/rc_channel_conditioner.sv.

module rc_channel_conditioner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Predicts the conditioned channel view for every accepted item and checks results
   // in order.
   class rc_cc_scoreboard;
      localparam int US_SPAN   = 1000;
      localparam int CMD_SCALE = 127;
      localparam int CMD_DIV   = 500;

      rc_cc_pkg::rsp_item_type expected_q [$];
      logic [10:0]             raw_ch [0:4];
      logic                    toggle_was_high;
      logic                    rise_latch;
      rc_cc_pkg::cfg_type      regs;
      int                      errors;
      int                      results_seen;

      function new();
         foreach (raw_ch[i]) raw_ch[i] = '0;
         toggle_was_high = 1'b0;
         rise_latch = 1'b0;
         regs.toggle_high_level  = rc_cc_pkg::TOGGLE_HIGH_RESET;
         regs.failsafe_band_low  = rc_cc_pkg::FS_LOW_RESET;
         regs.failsafe_band_high = rc_cc_pkg::FS_HIGH_RESET;
         regs.mute_band_low_us   = rc_cc_pkg::MUTE_LOW_RESET;
         regs.mute_band_high_us  = rc_cc_pkg::MUTE_HIGH_RESET;
         errors = 0;
         results_seen = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [10:0] value);
         case (index)
            rc_cc_pkg::CSR_TOGGLE_HIGH: regs.toggle_high_level = value;
            rc_cc_pkg::CSR_FS_LOW:      regs.failsafe_band_low = value;
            rc_cc_pkg::CSR_FS_HIGH:     regs.failsafe_band_high = value;
            rc_cc_pkg::CSR_MUTE_LOW:    regs.mute_band_low_us = value;
            rc_cc_pkg::CSR_MUTE_HIGH:   regs.mute_band_high_us = value;
            default: ;
         endcase
      endfunction

      static function int pulse_us(logic [10:0] raw);
         int v;
         v = int'(raw);
         if (v < int'(rc_cc_pkg::RAW_MIN)) v = int'(rc_cc_pkg::RAW_MIN);
         if (v > int'(rc_cc_pkg::RAW_MAX)) v = int'(rc_cc_pkg::RAW_MAX);
         return int'(rc_cc_pkg::US_MIN) + ((v - int'(rc_cc_pkg::RAW_MIN)) * US_SPAN)
            / int'(rc_cc_pkg::RAW_MAX - rc_cc_pkg::RAW_MIN);
      endfunction

      static function logic signed [7:0] command(int us);
         int d;
         d = us - int'(rc_cc_pkg::US_MID);
         return 8'((d * CMD_SCALE) / CMD_DIV);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(rc_cc_pkg::req_item_type it);
         rc_cc_pkg::rsp_item_type e;
         int                      steer, thr, tog, ovr, gear;
         logic                    link, hi;
         logic [1:0]              mode;
         e = '0;
         if (it.op == rc_cc_pkg::OP_UPDATE) begin
            if (it.channel <= rc_cc_pkg::CH_GEAR) begin
               raw_ch[it.channel] = it.raw_value;
               if (it.channel == rc_cc_pkg::CH_TOGGLE) begin
                  hi = it.raw_value > regs.toggle_high_level;
                  if (hi && !toggle_was_high) rise_latch = 1'b1;
                  toggle_was_high = hi;
               end
            end
         end else begin
            e.toggle_event = rise_latch;
            rise_latch = 1'b0;
         end
         steer = pulse_us(raw_ch[rc_cc_pkg::CH_STEER]);
         thr   = int'(rc_cc_pkg::INV_SUM) - pulse_us(raw_ch[rc_cc_pkg::CH_THROTTLE]);
         tog   = pulse_us(raw_ch[rc_cc_pkg::CH_TOGGLE]);
         ovr   = pulse_us(raw_ch[rc_cc_pkg::CH_OVERRIDE]);
         gear  = pulse_us(raw_ch[rc_cc_pkg::CH_GEAR]);
         link  = (raw_ch[rc_cc_pkg::CH_TOGGLE] < regs.failsafe_band_low) ||
                 (raw_ch[rc_cc_pkg::CH_TOGGLE] > regs.failsafe_band_high);
         if (ovr < int'(regs.mute_band_low_us)) mode = rc_cc_pkg::MODE_HOST;
         else if (ovr <= int'(regs.mute_band_high_us)) mode = rc_cc_pkg::MODE_MUTED;
         else mode = rc_cc_pkg::MODE_MANUAL;
         e.steer_pulse    = 11'(steer);
         e.throttle_pulse = 11'(thr);
         e.gear_us        = 11'(gear);
         e.override_us    = 11'(ovr);
         e.toggle_us      = 11'(tog);
         e.steer_cmd      = link ? command(steer) : 8'sd0;
         e.throttle_cmd   = link ? command(thr) : 8'sd0;
         e.high_gear      = link && (gear > int'(rc_cc_pkg::US_MID));
         e.override_on    = (mode != rc_cc_pkg::MODE_HOST) || !link;
         e.override_mode  = mode;
         e.link_up        = link;
         expected_q.push_back(e);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_field(string name, int got, int want);
         if (got != want)
            report($sformatf("result %0d %s: got %0d, expected %0d",
                             results_seen, name, got, want));
      endtask

      task check_result(rc_cc_pkg::rsp_item_type got);
         rc_cc_pkg::rsp_item_type e;
         results_seen++;
         if (expected_q.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
         end
         e = expected_q.pop_front();
         check_field("steer_pulse", got.steer_pulse, e.steer_pulse);
         check_field("throttle_pulse", got.throttle_pulse, e.throttle_pulse);
         check_field("gear_us", got.gear_us, e.gear_us);
         check_field("override_us", got.override_us, e.override_us);
         check_field("toggle_us", got.toggle_us, e.toggle_us);
         check_field("steer_cmd", got.steer_cmd, e.steer_cmd);
         check_field("throttle_cmd", got.throttle_cmd, e.throttle_cmd);
         check_field("high_gear", got.high_gear, e.high_gear);
         check_field("override_on", got.override_on, e.override_on);
         check_field("override_mode", got.override_mode, e.override_mode);
         check_field("link_up", got.link_up, e.link_up);
         check_field("toggle_event", got.toggle_event, e.toggle_event);
      endtask
   endclass

   localparam int LATENCY         = 3;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS     = 150;
   localparam int PULSE_SPAN      = 1000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [10:0] csr_wr_data;

   rc_cc_req_if req_bus ();
   rc_cc_rsp_if rsp_bus ();

   rc_channel_conditioner dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rc_cc_scoreboard    sb;
   rc_cc_pkg::cfg_type cur_cfg;
   int                 burst_left = 0;
   bit                 long_hold_req = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // smallest raw value whose pulse is at least us
   function automatic int raw_for_us(int us);
      return int'(rc_cc_pkg::RAW_MIN)
         + ((us - int'(rc_cc_pkg::US_MIN)) * int'(rc_cc_pkg::RAW_MAX - rc_cc_pkg::RAW_MIN)
            + PULSE_SPAN - 1) / PULSE_SPAN;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int sender_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst_left = $urandom_range(30, 120);
         return 0;
      end
      if (r < 55) return 0;
      return gap_length();
   endfunction

   // result side: random stalls, free-running stretches, one long hold on request
   initial begin : rsp_side
      int r, stall_left, free_left, hold_left;
      stall_left = 0;
      free_left = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = RSP_HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (free_left > 0) begin
            free_left--;
            rsp_bus.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
               free_left = $urandom_range(30, 150);
               rsp_bus.ready <= 1'b1;
            end else if (r < 70) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               stall_left = gap_length() - 1;
               rsp_bus.ready <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rc_cc_pkg::rsp_item_type got;
      rc_cc_pkg::req_item_type it;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.steer_pulse    = rsp_bus.steer_pulse;
            got.throttle_pulse = rsp_bus.throttle_pulse;
            got.gear_us        = rsp_bus.gear_us;
            got.override_us    = rsp_bus.override_us;
            got.toggle_us      = rsp_bus.toggle_us;
            got.steer_cmd      = rsp_bus.steer_cmd;
            got.throttle_cmd   = rsp_bus.throttle_cmd;
            got.high_gear      = rsp_bus.high_gear;
            got.override_on    = rsp_bus.override_on;
            got.override_mode  = rsp_bus.override_mode;
            got.link_up        = rsp_bus.link_up;
            got.toggle_event   = rsp_bus.toggle_event;
            sb.check_result(got);
         end
         if (req_bus.valid && req_bus.ready) begin
            it.op        = req_bus.op;
            it.channel   = req_bus.channel;
            it.raw_value = req_bus.raw_value;
            sb.note_request(it);
         end
      end
   end

   task automatic send_item(logic op, logic [2:0] ch, logic [10:0] raw);
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.channel   <= ch;
      req_bus.raw_value <= raw;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      gap = sender_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering items and wait until every expected result is in
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic program_regs(rc_cc_pkg::cfg_type c);
      logic [2:0]  idx  [0:4];
      logic [10:0] vals [0:4];
      idx  = '{rc_cc_pkg::CSR_TOGGLE_HIGH, rc_cc_pkg::CSR_FS_LOW, rc_cc_pkg::CSR_FS_HIGH,
               rc_cc_pkg::CSR_MUTE_LOW, rc_cc_pkg::CSR_MUTE_HIGH};
      vals = '{c.toggle_high_level, c.failsafe_band_low, c.failsafe_band_high,
               c.mute_band_low_us, c.mute_band_high_us};
      for (int i = 0; i < 5; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idx[i];
         csr_wr_data <= vals[i];
         @(posedge clock);
         sb.write_reg(idx[i], vals[i]);
      end
      csr_wr_en <= 1'b0;
      cur_cfg = c;
   endtask

   function automatic logic [10:0] near(int center, int spread);
      int v;
      v = center + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 2047) v = 2047;
      return 11'(v);
   endfunction

   // raw values, uniform or aimed at clamp edges and at every threshold of the current setting
   function automatic logic [10:0] pick_raw();
      case ($urandom_range(0, 9))
         4: return $urandom_range(0, 1) ? near(int'(rc_cc_pkg::RAW_MIN), 12)
                                        : near(int'(rc_cc_pkg::RAW_MAX), 12);
         5: return near(int'(cur_cfg.failsafe_band_low), 3);
         6: return near(int'(cur_cfg.failsafe_band_high), 3);
         7: return near(int'(cur_cfg.toggle_high_level), 3);
         8: return $urandom_range(0, 1)
               ? near(raw_for_us(int'(cur_cfg.mute_band_low_us)), 3)
               : near(raw_for_us(int'(cur_cfg.mute_band_high_us) + 1), 3);
         9: return near(raw_for_us(int'(rc_cc_pkg::US_MID)), 3);
         default: return 11'($urandom_range(0, 2047));
      endcase
   endfunction

   task automatic send_random();
      logic       op;
      logic [2:0] ch;
      int         r;
      op = ($urandom_range(0, 99) < 15) ? rc_cc_pkg::OP_POLL : rc_cc_pkg::OP_UPDATE;
      r = $urandom_range(0, 99);
      if (op == rc_cc_pkg::OP_POLL) ch = 3'($urandom_range(0, 7));
      else if (r < 10) ch = 3'($urandom_range(5, 7));
      else if (r < 30) ch = rc_cc_pkg::CH_TOGGLE;
      else ch = 3'($urandom_range(0, 4));
      send_item(op, ch,
                (op == rc_cc_pkg::OP_POLL) ? 11'($urandom_range(0, 2047)) : pick_raw());
   endtask

   function automatic rc_cc_pkg::cfg_type random_cfg();
      rc_cc_pkg::cfg_type c;
      c.toggle_high_level  = 11'($urandom_range(0, 2047));
      c.failsafe_band_low  = 11'($urandom_range(0, 2047));
      c.failsafe_band_high = 11'($urandom_range(0, 2047));
      c.mute_band_low_us   = 11'($urandom_range(1000, 2000));
      c.mute_band_high_us  = 11'($urandom_range(1000, 2000));
      return c;
   endfunction

   task automatic random_phase();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n == PHASE_ITEMS / 2) drain();
         send_random();
      end
   endtask

   initial begin : main
      sb = new();
      cur_cfg = sb.regs;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.op        <= rc_cc_pkg::OP_UPDATE;
      req_bus.channel   <= rc_cc_pkg::CH_STEER;
      req_bus.raw_value <= '0;
      csr_wr_en         <= 1'b0;
      csr_index         <= rc_cc_pkg::CSR_TOGGLE_HIGH;
      csr_wr_data       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: clamp edges, inversion, gear and mute thresholds, toggle latch, link band
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_STEER, 11'd0);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_STEER, 11'd172);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_STEER, 11'd1811);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_STEER, 11'd1812);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_STEER, 11'd2047);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_THROTTLE, 11'd0);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_THROTTLE, 11'd2047);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_GEAR, 11'd993);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_GEAR, 11'd994);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_OVERRIDE, 11'd0);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_OVERRIDE, 11'(raw_for_us(1400)));
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_OVERRIDE, 11'(raw_for_us(1601) - 1));
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_OVERRIDE, 11'(raw_for_us(1601)));
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_TOGGLE, 11'd501);
      send_item(rc_cc_pkg::OP_POLL, rc_cc_pkg::CH_STEER, 11'd0);
      send_item(rc_cc_pkg::OP_POLL, rc_cc_pkg::CH_STEER, 11'd0);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_TOGGLE, 11'd800);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_TOGGLE, 11'd1200);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_TOGGLE, 11'd1201);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_TOGGLE, 11'd0);
      send_item(rc_cc_pkg::OP_UPDATE, rc_cc_pkg::CH_TOGGLE, 11'd2047);
      send_item(rc_cc_pkg::OP_UPDATE, 3'd5, 11'd2047);
      send_item(rc_cc_pkg::OP_UPDATE, 3'd7, 11'd2047);
      send_item(rc_cc_pkg::OP_POLL, 3'd7, 11'd2047);

      // hold the result side off while items keep coming, so the pipeline backs up
      long_hold_req = 1'b1;
      burst_left = 40;
      repeat (40) send_random();
      drain();

      random_phase();
      drain();
      program_regs('{11'd0, 11'd0, 11'd0, 11'd1000, 11'd1000});
      random_phase();
      drain();
      program_regs('{11'd2047, 11'd2047, 11'd2047, 11'd2000, 11'd2000});
      random_phase();
      drain();
      // inverted bands
      program_regs('{11'd1024, 11'd1500, 11'd400, 11'd1800, 11'd1200});
      random_phase();
      drain();
      program_regs('{rc_cc_pkg::TOGGLE_HIGH_RESET, rc_cc_pkg::FS_LOW_RESET,
                     rc_cc_pkg::FS_HIGH_RESET, rc_cc_pkg::MUTE_LOW_RESET,
                     rc_cc_pkg::MUTE_HIGH_RESET});
      random_phase();
      for (int p = 0; p < 3; p++) begin
         drain();
         program_regs(random_cfg());
         random_phase();
      end

      drain();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

// File: filelist.f
hdl/rc_cc_pkg.sv
hdl/rc_cc_if.sv
hdl/rc_cc_map.sv
hdl/rc_cc_state.sv
hdl/rc_channel_conditioner.sv
sim/rc_channel_conditioner_tb.sv
